// ===== hdl/ldsa_pkg.sv =====
// Shared types and codes for the local data share access block.
// Used by the front, back and top-level modules; depends on nothing.
package ldsa_pkg;

    typedef enum logic [3:0] {
        OP_WR32  = 4'd0,
        OP_WR8   = 4'd1,
        OP_WR16  = 4'd2,
        OP_RD32  = 4'd3,
        OP_RD2X32 = 4'd4,
        OP_RDI8  = 4'd5,
        OP_RDU8  = 4'd6,
        OP_RDI16 = 4'd7,
        OP_RDU16 = 4'd8
    } op_t;

    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_HALF = 2'd1,
        SZ_WORD = 2'd2
    } size_t;

    typedef struct packed {
        logic  write;
        logic  read;
        logic  pair;
        logic  sext;
        size_t size;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SECOND = 2'd1,
        ST_FINISH = 2'd2
    } state_t;

    localparam int unsigned LANES = 4;

endpackage

// ===== hdl/ldsa_ram.sv =====
// Generic single-port RAM with registered read data.
// Standalone; used for each byte bank of the share memory.
module ldsa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/ldsa_queue.sv =====
// Small register queue between the front and back parts.
// Standalone; the entry is an opaque packed vector.
module ldsa_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/ldsa_front.sv =====
// Front part: accepts input transfers, decodes the operation and forms the
// wrapped byte addresses. Depends on ldsa_pkg.
module ldsa_front #(
    parameter int unsigned AW = 16
) (
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [71:0]        s_tdata,
    input  logic               q_full,
    output logic               q_push,
    output ldsa_pkg::cmd_t     cmd_ctl,
    output logic [AW-1:0]      cmd_base0,
    output logic [AW-1:0]      cmd_base1,
    output logic [31:0]        cmd_wdata
);

    localparam int unsigned SW = (AW > 18) ? AW : 18;

    ldsa_pkg::op_t op;
    logic [15:0]   byte_address;
    logic [7:0]    first_offset;
    logic [7:0]    second_offset;
    logic [SW-1:0] addr_ext;
    logic [SW-1:0] sum0;
    logic [SW-1:0] sum1;

    assign op            = ldsa_pkg::op_t'(s_tdata[3:0]);
    assign byte_address  = s_tdata[19:4];
    assign cmd_wdata     = s_tdata[51:20];
    assign first_offset  = s_tdata[59:52];
    assign second_offset = s_tdata[67:60];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    assign addr_ext = SW'(byte_address);
    assign sum0     = addr_ext + (SW'(first_offset) << 2);
    assign sum1     = addr_ext + (SW'(second_offset) << 2);

    always_comb begin
        cmd_ctl       = '0;
        cmd_ctl.size  = ldsa_pkg::SZ_WORD;
        cmd_base0     = addr_ext[AW-1:0];
        cmd_base1     = sum1[AW-1:0];
        unique case (op)
            ldsa_pkg::OP_WR32: begin
                cmd_ctl.write = 1'b1;
            end
            ldsa_pkg::OP_WR8: begin
                cmd_ctl.write = 1'b1;
                cmd_ctl.size  = ldsa_pkg::SZ_BYTE;
            end
            ldsa_pkg::OP_WR16: begin
                cmd_ctl.write = 1'b1;
                cmd_ctl.size  = ldsa_pkg::SZ_HALF;
            end
            ldsa_pkg::OP_RD32: begin
                cmd_ctl.read = 1'b1;
            end
            ldsa_pkg::OP_RD2X32: begin
                cmd_ctl.read = 1'b1;
                cmd_ctl.pair = 1'b1;
                cmd_base0    = sum0[AW-1:0];
            end
            ldsa_pkg::OP_RDI8: begin
                cmd_ctl.read = 1'b1;
                cmd_ctl.sext = 1'b1;
                cmd_ctl.size = ldsa_pkg::SZ_BYTE;
            end
            ldsa_pkg::OP_RDU8: begin
                cmd_ctl.read = 1'b1;
                cmd_ctl.size = ldsa_pkg::SZ_BYTE;
            end
            ldsa_pkg::OP_RDI16: begin
                cmd_ctl.read = 1'b1;
                cmd_ctl.sext = 1'b1;
                cmd_ctl.size = ldsa_pkg::SZ_HALF;
            end
            ldsa_pkg::OP_RDU16: begin
                cmd_ctl.read = 1'b1;
                cmd_ctl.size = ldsa_pkg::SZ_HALF;
            end
            default: begin
                cmd_ctl = '0;
            end
        endcase
    end

endmodule

// ===== hdl/ldsa_back.sv =====
// Back part: sequences the byte-bank accesses of one command, assembles read
// data and holds the result register. Depends on ldsa_pkg and ldsa_ram.
module ldsa_back #(
    parameter int unsigned AW = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_pop,
    input  ldsa_pkg::cmd_t q_ctl,
    input  logic [AW-1:0]  q_base0,
    input  logic [31:0]    q_wdata,
    input  logic [AW-1:0]  q_base1,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [63:0]    m_tdata
);

    localparam int unsigned RW    = AW - 2;
    localparam int unsigned LANES = ldsa_pkg::LANES;

    ldsa_pkg::state_t state_reg, state_next;
    ldsa_pkg::cmd_t   ctl_reg, ctl_next;
    logic [AW-1:0]    base1_reg, base1_next;
    logic [1:0]       lane_reg, lane_next;
    logic [31:0]      word0_reg, word0_next;
    logic             out_valid_reg, out_valid_next;
    logic [63:0]      out_data_reg, out_data_next;

    logic             start;
    logic             issue;
    logic             acc_write;
    logic [AW-1:0]    acc_base;
    logic [2:0]       acc_nbytes;
    logic [RW-1:0]    row0;
    logic [RW-1:0]    row1;
    logic [1:0]       lane_idx [LANES];
    logic             bank_we [LANES];
    logic [RW-1:0]    bank_addr [LANES];
    logic [7:0]       bank_wdata [LANES];
    logic [7:0]       bank_rdata [LANES];
    logic [31:0]      word;
    logic [31:0]      narrow_word;

    assign start = (state_reg == ldsa_pkg::ST_IDLE) && q_valid
                   && (!out_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ldsa_pkg::ST_IDLE: begin
                if (start) begin
                    state_next = q_ctl.pair ? ldsa_pkg::ST_SECOND : ldsa_pkg::ST_FINISH;
                end
            end
            ldsa_pkg::ST_SECOND: begin
                state_next = ldsa_pkg::ST_FINISH;
            end
            ldsa_pkg::ST_FINISH: begin
                state_next = ldsa_pkg::ST_IDLE;
            end
            default: begin
                state_next = ldsa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        q_pop      = 1'b0;
        issue      = 1'b0;
        acc_write  = 1'b0;
        acc_base   = q_base0;
        ctl_next   = ctl_reg;
        base1_next = base1_reg;
        lane_next  = lane_reg;
        word0_next = word0_reg;
        unique case (state_reg)
            ldsa_pkg::ST_IDLE: begin
                if (start) begin
                    q_pop      = 1'b1;
                    issue      = 1'b1;
                    acc_write  = q_ctl.write;
                    ctl_next   = q_ctl;
                    base1_next = q_base1;
                end
            end
            ldsa_pkg::ST_SECOND: begin
                issue      = 1'b1;
                acc_base   = base1_reg;
                word0_next = word;
            end
            default: begin
            end
        endcase
        if (issue) begin
            lane_next = acc_base[1:0];
        end
    end

    always_comb begin
        unique case (q_ctl.size)
            ldsa_pkg::SZ_BYTE: acc_nbytes = 3'd1;
            ldsa_pkg::SZ_HALF: acc_nbytes = 3'd2;
            ldsa_pkg::SZ_WORD: acc_nbytes = 3'd4;
            default:           acc_nbytes = 3'd0;
        endcase
    end

    assign row0 = acc_base[AW-1:2];
    assign row1 = row0 + RW'(1);

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            lane_idx[k]   = 2'(k) - acc_base[1:0];
            bank_addr[k]  = (2'(k) < acc_base[1:0]) ? row1 : row0;
            bank_we[k]    = acc_write && ({1'b0, lane_idx[k]} < acc_nbytes);
            bank_wdata[k] = 8'(q_wdata >> {lane_idx[k], 3'b000});
        end
    end

    for (genvar k = 0; k < LANES; k++) begin : g_bank
        ldsa_ram #(
            .WIDTH(8),
            .DEPTH(2 ** RW)
        ) u_bank (
            .aclk (aclk),
            .we   (bank_we[k]),
            .addr (bank_addr[k]),
            .wdata(bank_wdata[k]),
            .rdata(bank_rdata[k])
        );
    end

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            word[8*j +: 8] = bank_rdata[2'(lane_reg + 2'(j))];
        end
    end

    always_comb begin
        unique case (ctl_reg.size)
            ldsa_pkg::SZ_BYTE: narrow_word = {{24{ctl_reg.sext & word[7]}}, word[7:0]};
            ldsa_pkg::SZ_HALF: narrow_word = {{16{ctl_reg.sext & word[15]}}, word[15:0]};
            ldsa_pkg::SZ_WORD: narrow_word = word;
            default:           narrow_word = '0;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        if (state_reg == ldsa_pkg::ST_FINISH) begin
            out_valid_next = 1'b1;
            if (!ctl_reg.read) begin
                out_data_next = '0;
            end else if (ctl_reg.pair) begin
                out_data_next = {word, word0_reg};
            end else begin
                out_data_next = {32'd0, narrow_word};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ldsa_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ctl_reg      <= ctl_next;
        base1_reg    <= base1_next;
        lane_reg     <= lane_next;
        word0_reg    <= word0_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== hdl/local_data_share_access_core.sv =====
// One lane's access to a byte-addressed local data share of MEM_BYTES bytes
// (a power of two), built as four byte-wide banks so that any unaligned dword
// touches each bank once. The back part runs an access state (repeated for a
// paired dword read, one port per bank), then a finish state on registered
// read data, and takes no new item until the last ends; a two-entry queue lets
// the input keep accepting while the back part works or its result waits. The
// memory has no reset and no clearing pass: a byte reads back only after it was
// written. Depends on ldsa_pkg, ldsa_front, ldsa_queue, ldsa_back, ldsa_ram.
module local_data_share_access_core #(
    parameter int unsigned MEM_BYTES = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[3:0], byte_address[19:4], write_data[51:20], first_offset[59:52],
    // second_offset[67:60], zero fill [71:68]
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_word[31:0], second_word[63:32]
    output logic [63:0] m_tdata
);

    localparam int unsigned AW = $clog2(MEM_BYTES);
    localparam int unsigned CW = $bits(ldsa_pkg::cmd_t);
    localparam int unsigned QW = CW + 2 * AW + 32;

    ldsa_pkg::cmd_t cmd_ctl;
    logic [AW-1:0]  cmd_base0;
    logic [AW-1:0]  cmd_base1;
    logic [31:0]    cmd_wdata;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_valid;
    logic [QW-1:0]  q_head;
    ldsa_pkg::cmd_t q_ctl;
    logic [AW-1:0]  q_base0;
    logic [AW-1:0]  q_base1;
    logic [31:0]    q_wdata;

    ldsa_front #(
        .AW(AW)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .cmd_ctl  (cmd_ctl),
        .cmd_base0(cmd_base0),
        .cmd_base1(cmd_base1),
        .cmd_wdata(cmd_wdata)
    );

    ldsa_queue #(
        .WIDTH(QW),
        .DEPTH(2)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data({cmd_ctl, cmd_base0, cmd_base1, cmd_wdata}),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_data (q_head)
    );

    assign q_ctl   = ldsa_pkg::cmd_t'(q_head[QW-1 -: CW]);
    assign q_base0 = q_head[2*AW+31 -: AW];
    assign q_base1 = q_head[AW+31 -: AW];
    assign q_wdata = q_head[31:0];

    ldsa_back #(
        .AW(AW)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_ctl   (q_ctl),
        .q_base0 (q_base0),
        .q_wdata (q_wdata),
        .q_base1 (q_base1),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

endmodule

// ===== tb/tb_local_data_share_access_core.sv =====
// Self-checking bench for local_data_share_access_core: directed and random loads and stores.
// It keeps its own byte image of the share to predict every result transfer.
// Depends on ldsa_pkg and the RTL under hdl.
module tb_local_data_share_access_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MEM_BYTES     = 65536;
    localparam int unsigned ITEM_TARGET   = 1800;
    localparam int unsigned HOT_BASE      = 16'hFE00;
    localparam int unsigned HOT_SPAN      = 1024;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned DRAIN_CYCLES  = 20;
    localparam logic [3:0]  OP_UNUSED_LO  = 4'd9;
    localparam logic [3:0]  OP_UNUSED_HI  = 4'd15;

    typedef struct packed {
        logic [31:0] second_word;
        logic [31:0] read_word;
    } lds_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;

    logic [71:0] pending_items [$];
    lds_result_t expected_results [$];
    logic [7:0]  share_image [MEM_BYTES];
    bit          byte_written [MEM_BYTES];

    int unsigned total_items = 0;
    int unsigned accepted_count = 0;
    int unsigned checked_count = 0;
    int unsigned error_count = 0;
    int unsigned write_items = 0;
    int unsigned read_items = 0;
    int unsigned pair_items = 0;
    int unsigned unused_items = 0;
    int unsigned sender_idle;
    int unsigned receiver_idle;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    local_data_share_access_core #(
        .MEM_BYTES(MEM_BYTES)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned wrap(int unsigned base, int unsigned idx);
        return (base + idx) % MEM_BYTES;
    endfunction

    function automatic logic [31:0] fetch_le(int unsigned base, int unsigned count);
        logic [31:0] v;
        v = '0;
        for (int unsigned i = 0; i < count; i++) begin
            v |= 32'(share_image[wrap(base, i)]) << (8 * i);
        end
        return v;
    endfunction

    function automatic void store_le(int unsigned base, int unsigned count, logic [31:0] data);
        for (int unsigned i = 0; i < count; i++) begin
            share_image[wrap(base, i)] = data[8*i +: 8];
        end
    endfunction

    function automatic lds_result_t predict_access(logic [71:0] item);
        logic [3:0]  op;
        logic [15:0] addr;
        logic [31:0] data;
        logic [7:0]  off0;
        logic [7:0]  off1;
        logic [31:0] v;
        lds_result_t r;
        op   = item[3:0];
        addr = item[19:4];
        data = item[51:20];
        off0 = item[59:52];
        off1 = item[67:60];
        r = '0;
        case (op)
            ldsa_pkg::OP_WR32:   store_le(addr, 4, data);
            ldsa_pkg::OP_WR8:    store_le(addr, 1, data);
            ldsa_pkg::OP_WR16:   store_le(addr, 2, data);
            ldsa_pkg::OP_RD32:   r.read_word = fetch_le(addr, 4);
            ldsa_pkg::OP_RD2X32: begin
                r.read_word   = fetch_le(addr + 4 * off0, 4);
                r.second_word = fetch_le(addr + 4 * off1, 4);
            end
            ldsa_pkg::OP_RDI8: begin
                v = fetch_le(addr, 1);
                r.read_word = {{24{v[7]}}, v[7:0]};
            end
            ldsa_pkg::OP_RDU8:   r.read_word = fetch_le(addr, 1);
            ldsa_pkg::OP_RDI16: begin
                v = fetch_le(addr, 2);
                r.read_word = {{16{v[15]}}, v[15:0]};
            end
            ldsa_pkg::OP_RDU16:  r.read_word = fetch_le(addr, 2);
            default:             r = '0;
        endcase
        return r;
    endfunction

    function automatic bit span_written(int unsigned base, int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            if (!byte_written[wrap(base, i)]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int unsigned access_bytes(logic [3:0] op);
        case (op)
            ldsa_pkg::OP_WR32, ldsa_pkg::OP_RD32:                       return 4;
            ldsa_pkg::OP_WR16, ldsa_pkg::OP_RDI16, ldsa_pkg::OP_RDU16: return 2;
            ldsa_pkg::OP_WR8, ldsa_pkg::OP_RDI8, ldsa_pkg::OP_RDU8:    return 1;
            default:                                                   return 0;
        endcase
    endfunction

    // Queues one item and keeps the written map in stimulus order.
    task automatic add_item(logic [3:0] op, int unsigned addr, logic [31:0] data,
                            logic [7:0] off0, logic [7:0] off1);
        logic [15:0] a;
        a = addr[15:0];
        if (op == ldsa_pkg::OP_WR32 || op == ldsa_pkg::OP_WR16
            || op == ldsa_pkg::OP_WR8) begin
            for (int unsigned i = 0; i < access_bytes(op); i++) begin
                byte_written[wrap(a, i)] = 1'b1;
            end
            write_items++;
        end else if (op == ldsa_pkg::OP_RD2X32) begin
            pair_items++;
        end else if (op >= OP_UNUSED_LO) begin
            unused_items++;
        end else begin
            read_items++;
        end
        pending_items.push_back({4'b0000, off1, off0, data, a, op});
        total_items++;
    endtask

    function automatic int unsigned hot_addr();
        return wrap(HOT_BASE, $urandom_range(HOT_SPAN - 4, 0));
    endfunction

    task automatic add_directed();
        add_item(ldsa_pkg::OP_WR32, 16'h0000, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
        add_item(ldsa_pkg::OP_RD32, 16'h0000, 32'h0, 8'hFF, 8'hFF);
        add_item(ldsa_pkg::OP_WR32, 16'hFFFE, 32'h80A5_5A01, 8'h00, 8'h00);
        add_item(ldsa_pkg::OP_RD32, 16'hFFFE, 32'h0, 8'h00, 8'h00);
        add_item(ldsa_pkg::OP_RDU16, 16'hFFFF, 32'h0, 8'h00, 8'h00);
        add_item(ldsa_pkg::OP_RDI16, 16'h0000, 32'h0, 8'h00, 8'h00);
        add_item(ldsa_pkg::OP_RDI8, 16'h0001, 32'h0, 8'h00, 8'h00);
        add_item(ldsa_pkg::OP_RDU8, 16'h0001, 32'h0, 8'h00, 8'h00);
        add_item(ldsa_pkg::OP_RDI8, 16'hFFFF, 32'h0, 8'h00, 8'h00);
        add_item(ldsa_pkg::OP_WR8, 16'h1232, 32'hFFFF_FFFE, 8'hAA, 8'h55);
        add_item(ldsa_pkg::OP_WR16, 16'h1233, 32'h1234_8001, 8'h00, 8'h00);
        add_item(ldsa_pkg::OP_WR8, 16'h1235, 32'hFFFF_FF7F, 8'h00, 8'h00);
        add_item(ldsa_pkg::OP_WR8, 16'h1236, 32'h0000_0000, 8'h00, 8'h00);
        add_item(ldsa_pkg::OP_RD32, 16'h1233, 32'h0, 8'h00, 8'h00);
        add_item(ldsa_pkg::OP_RDI16, 16'h1233, 32'h0, 8'h00, 8'h00);
        add_item(ldsa_pkg::OP_WR32, 16'h1000, 32'hDEAD_BEEF, 8'h00, 8'h00);
        add_item(ldsa_pkg::OP_WR32, 16'h13FC, 32'h0123_4567, 8'h00, 8'h00);
        add_item(ldsa_pkg::OP_RD2X32, 16'h1000, 32'h0, 8'h00, 8'hFF);
        add_item(ldsa_pkg::OP_RD2X32, 16'h1000, 32'hFFFF_FFFF, 8'hFF, 8'h00);
        add_item(ldsa_pkg::OP_RD2X32, 16'hFC02, 32'h0, 8'hFF, 8'hFF);
        add_item(OP_UNUSED_LO, 16'h0000, 32'h1111_1111, 8'h01, 8'h02);
        add_item(OP_UNUSED_HI, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
        add_item(ldsa_pkg::OP_RD32, 16'h0000, 32'h0, 8'h00, 8'h00);
    endtask

    task automatic add_random();
        int unsigned pick;
        int unsigned addr;
        logic [7:0]  off0;
        logic [7:0]  off1;
        logic [3:0]  op;
        bit          found;
        // A dword sweep over the hot window so that reads there are always legal.
        for (int unsigned k = 0; k < HOT_SPAN / 4; k++) begin
            add_item(ldsa_pkg::OP_WR32, wrap(HOT_BASE, 4 * k), $urandom(),
                     8'($urandom()), 8'($urandom()));
        end
        while (total_items < ITEM_TARGET) begin
            pick = $urandom_range(99, 0);
            off0 = 8'($urandom());
            off1 = 8'($urandom());
            if (pick < 4) begin
                add_item(4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO)), $urandom_range(65535, 0),
                         $urandom(), off0, off1);
            end else if (pick < 10) begin
                op = 4'($urandom_range(ldsa_pkg::OP_WR16, ldsa_pkg::OP_WR32));
                add_item(op, $urandom_range(65535, 0), $urandom(), off0, off1);
            end else if (pick < 45) begin
                op = 4'($urandom_range(ldsa_pkg::OP_WR16, ldsa_pkg::OP_WR32));
                add_item(op, hot_addr(), $urandom(), off0, off1);
            end else if (pick < 60) begin
                found = 1'b0;
                for (int unsigned t = 0; t < 16 && !found; t++) begin
                    addr = hot_addr();
                    off0 = 8'($urandom());
                    off1 = 8'($urandom());
                    found = span_written(addr + 4 * off0, 4) && span_written(addr + 4 * off1, 4);
                end
                if (!found) begin
                    off0 = 8'($urandom_range(3, 0));
                    off1 = 8'($urandom_range(3, 0));
                    found = span_written(addr + 4 * off0, 4) && span_written(addr + 4 * off1, 4);
                end
                if (found) begin
                    add_item(ldsa_pkg::OP_RD2X32, addr, $urandom(), off0, off1);
                end
            end else begin
                op = 4'($urandom_range(ldsa_pkg::OP_RDU16, ldsa_pkg::OP_RD32));
                if (op == ldsa_pkg::OP_RD2X32) op = ldsa_pkg::OP_RD32;
                addr = hot_addr();
                if (span_written(addr, access_bytes(op))) begin
                    add_item(op, addr, $urandom(), off0, off1);
                end
            end
        end
    endtask

    always_comb begin
        if (accepted_count < total_items / 3) begin
            sender_idle   = 36;
            receiver_idle = 79;
        end else if (accepted_count < 2 * total_items / 3) begin
            sender_idle   = 79;
            receiver_idle = 36;
        end else begin
            sender_idle   = 0;
            receiver_idle = 0;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(predict_access(s_tdata));
                accepted_count <= accepted_count + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() != 0 && $urandom_range(99, 0) >= sender_idle) begin
                    s_tdata  <= pending_items.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // A long receiver stall once idling stops, so the input side must back up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && total_items != 0
                     && accepted_count >= 2 * total_items / 3 + 20) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        lds_result_t want;
        lds_result_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result transfer, actual %h", $time, m_tdata);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.read_word !== want.read_word) begin
                        $display("%0t: read_word mismatch, expected %h actual %h",
                                 $time, want.read_word, got.read_word);
                        error_count++;
                    end
                    if (got.second_word !== want.second_word) begin
                        $display("%0t: second_word mismatch, expected %h actual %h",
                                 $time, want.second_word, got.second_word);
                        error_count++;
                    end
                    checked_count++;
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99, 0) >= receiver_idle);
        end
    end

    initial begin
        #5_000_000;
        $display("local_data_share_access_core verification failed");
        $finish;
    end

    initial begin
        for (int unsigned i = 0; i < MEM_BYTES; i++) begin
            share_image[i]  = '0;
            byte_written[i] = 1'b0;
        end
        add_directed();
        add_random();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        while (accepted_count != total_items) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d items: %0d writes, %0d narrow/dword reads, %0d paired reads,",
                 total_items, write_items, read_items, pair_items);
        $display("%0d unused codes; %0d result transfers checked, %0d errors.",
                 unused_items, checked_count, error_count);
        if (error_count == 0) begin
            $display("local_data_share_access_core verification clean");
        end else begin
            $display("local_data_share_access_core verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ldsa_pkg.sv
hdl/ldsa_ram.sv
hdl/ldsa_queue.sv
hdl/ldsa_front.sv
hdl/ldsa_back.sv
hdl/local_data_share_access_core.sv
tb/tb_local_data_share_access_core.sv
